// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/lfpid_pkg.sv =====
// Types and constants of the line follower PID motor drive.
package lfpid_pkg;

	// Sequencer states, one-hot
	typedef enum logic [8:0] {
		S_IDLE  = 9'b0_0000_0001,
		S_DIV   = 9'b0_0000_0010,
		S_SIGN  = 9'b0_0000_0100,
		S_MUL_I = 9'b0_0000_1000,
		S_MUL_P = 9'b0_0001_0000,
		S_MUL_D = 9'b0_0010_0000,
		S_SPEED = 9'b0_0100_0000,
		S_ROUND = 9'b0_1000_0000,
		S_DRIVE = 9'b1_0000_0000
	} lfpid_state_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_ADC_THRESHOLD = 3'd0,
		REG_GAIN_P        = 3'd1,
		REG_GAIN_I        = 3'd2,
		REG_GAIN_D        = 3'd3,
		REG_DEAD_ZONE     = 3'd4,
		REG_SPEED_NORMAL  = 3'd5,
		REG_SPEED_CROWDED = 3'd6,
		REG_CROWD_COUNT   = 3'd7
	} lfpid_cfg_reg_t;

	localparam int NUM_POS = 14;

	// Digital sensor bits that take part; positions 2 to 5 come from the ADC
	localparam logic [NUM_POS-1:0] DIGITAL_MASK = 14'h3FC3;

	// Position weights in half units, outer sensors boosted
	localparam logic signed [7:0] POS_WEIGHT [NUM_POS] = '{
		-8'sd23, -8'sd18, -8'sd9, -8'sd7, -8'sd5, -8'sd3, -8'sd1,
		8'sd1, 8'sd3, 8'sd5, 8'sd7, 8'sd9, 8'sd18, 8'sd23
	};

	// Register reset values
	localparam logic [7:0] RST_ADC_THRESHOLD = 8'd80;
	localparam logic [7:0] RST_GAIN_P        = 8'd13;
	localparam logic [7:0] RST_GAIN_I        = 8'd133;
	localparam logic [7:0] RST_GAIN_D        = 8'd8;
	localparam logic [6:0] RST_DEAD_ZONE     = 7'd22;
	localparam logic [7:0] RST_SPEED_NORMAL  = 8'd60;
	localparam logic [7:0] RST_SPEED_CROWDED = 8'd48;
	localparam logic [3:0] RST_CROWD_COUNT   = 4'd5;

endpackage

// ===== rtl/core/line_follower_pid_motor_drive.sv =====
// Line follower PID controller: sensor error, PID turn and wheel drive outputs.
//
// One transaction per control tick. An accepted tick leaves in_stall high until its
// result is in the output register. A tick with at least one line hit passes through
// the restoring divider that forms the line error one quotient bit per cycle,
// followed by three passes through the one shared multiplier (integral, proportional,
// derivative) and three short finishing steps. A tick with no hits skips the divider.
// The last step waits as long as a previous result is held in the output register
// by out_stall. A finished result waits in the output register while the next tick
// is already being worked on.
// Configuration writes are always taken and must only be issued while idle.

`include "assert_macros.svh"

module line_follower_pid_motor_drive #(
	parameter int ERROR_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [13:0] digital_sensors,
	input  logic [7:0]  adc_sensor_two,
	input  logic [7:0]  adc_sensor_three,
	input  logic [7:0]  adc_sensor_four,
	input  logic [7:0]  adc_sensor_five,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        left_forward,
	output logic [7:0]  left_pwm,
	output logic        right_forward,
	output logic [7:0]  right_pwm,
	output logic [3:0]  hit_count
);

	localparam int F   = ERROR_FRAC_BITS;
	localparam int EW  = F + 6;   // error
	localparam int IW  = F + 13;  // integral
	localparam int MAW = F + 14;  // multiplier signed operand
	localparam int PW  = MAW + 9; // product
	localparam int TW  = F + 16;  // turn accumulator
	localparam int SW  = F + 17;  // fixed-point wheel speed
	localparam int RW  = 18;      // rounded wheel speed
	localparam int DRW = RW + 1;  // after dead-zone shift
	localparam int DW  = F + 7;   // dividend and quotient
	localparam int CW  = $clog2(DW);
	localparam logic [SW-1:0] HALF = SW'(1) << (F - 1);

	// Configuration registers
	logic [7:0] adc_threshold_q;
	logic [7:0] gain_p_q;
	logic [7:0] gain_i_q;
	logic [7:0] gain_d_q;
	logic [6:0] dead_zone_q;
	logic [7:0] speed_normal_q;
	logic [7:0] speed_crowded_q;
	logic [3:0] crowd_count_q;

	lfpid_pkg::lfpid_state_t state_q;

	// Controller state
	logic signed [EW-1:0] last_error_q;
	logic signed [IW-1:0] integ_q;

	// Working registers
	logic [3:0]           count_q;
	logic                 neg_q;
	logic [DW-1:0]        quo_q;
	logic [4:0]           rem_q;
	logic [4:0]           div_q;
	logic [CW-1:0]        step_q;
	logic signed [EW-1:0] err_q;
	logic signed [TW-1:0] acc_q;
	logic signed [SW-1:0] lspd_q;
	logic signed [SW-1:0] rspd_q;
	logic signed [RW-1:0] lrnd_q;
	logic signed [RW-1:0] rrnd_q;

	// Output register
	logic       out_valid_q;
	logic       left_fwd_q;
	logic [7:0] left_pwm_q;
	logic       right_fwd_q;
	logic [7:0] right_pwm_q;
	logic [3:0] hit_count_q;

	// Combinational signals
	logic [13:0]          hits;
	logic [3:0]           hit_cnt;
	logic signed [7:0]    hit_sum;
	logic [6:0]           sum_mag;
	logic [DW-1:0]        dividend;
	logic [5:0]           trial;
	logic                 trial_ge;
	logic signed [MAW-1:0] op_a;
	logic [7:0]           op_b;
	logic signed [PW-1:0] prod;
	logic [7:0]           base_sel;
	logic signed [SW-1:0] base_fx;
	logic [8:0]           left_drv;
	logic [8:0]           right_drv;
	logic                 out_free;

	// Round a fixed-point speed to an integer, half away from zero
	function automatic logic signed [RW-1:0] round_fn(input logic signed [SW-1:0] v);
		logic [SW-1:0]        mag;
		logic [SW-1:0]        sum;
		logic signed [RW-1:0] rr;
		mag = v[SW-1] ? SW'(-v) : SW'(v);
		sum = mag + HALF;
		rr = $signed(RW'(sum[SW-1:F]));
		return v[SW-1] ? -rr : rr;
	endfunction

	// Apply dead zone, then form direction and saturated magnitude
	function automatic logic [8:0] drive_fn(input logic signed [RW-1:0] r,
			input logic [6:0] dz);
		logic signed [DRW-1:0] s;
		logic signed [DRW-1:0] dz_s;
		logic [DRW-1:0]        mag;
		logic                  fwd;
		logic [7:0]            pwm;
		s = DRW'(r);
		dz_s = $signed(DRW'(dz));
		if (s < dz_s) begin
			s = s - (dz_s <<< 1);
		end
		mag = s[DRW-1] ? DRW'(-s) : DRW'(s);
		fwd = !s[DRW-1] && (s != '0);
		pwm = (mag > DRW'(255)) ? 8'hFF : mag[7:0];
		return {fwd, pwm};
	endfunction

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != lfpid_pkg::S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// Sensor hits, hit count and weighted sum
	always_comb begin
		hits = digital_sensors & lfpid_pkg::DIGITAL_MASK;
		hits[2] = (adc_sensor_two   > adc_threshold_q);
		hits[3] = (adc_sensor_three > adc_threshold_q);
		hits[4] = (adc_sensor_four  > adc_threshold_q);
		hits[5] = (adc_sensor_five  > adc_threshold_q);
		hit_cnt = '0;
		hit_sum = '0;
		for (int k = 0; k < lfpid_pkg::NUM_POS; k++) begin
			if (hits[k]) begin
				hit_cnt = hit_cnt + 4'd1;
				hit_sum = hit_sum + lfpid_pkg::POS_WEIGHT[k];
			end
		end
		sum_mag  = hit_sum[7] ? 7'(-hit_sum) : hit_sum[6:0];
		dividend = {sum_mag, {F{1'b0}}} | DW'(hit_cnt);
	end

	// Divider step: shift in next dividend bit, subtract if it fits
	assign trial    = {rem_q, quo_q[DW-1]};
	assign trial_ge = (trial >= {1'b0, div_q});

	// Shared multiplier operand select
	always_comb begin
		case (state_q)
			lfpid_pkg::S_MUL_I: begin
				op_a = MAW'(integ_q) + MAW'(err_q);
				op_b = gain_i_q;
			end
			lfpid_pkg::S_MUL_P: begin
				op_a = MAW'(err_q);
				op_b = gain_p_q;
			end
			default: begin
				op_a = MAW'(err_q) - MAW'(last_error_q);
				op_b = gain_d_q;
			end
		endcase
		prod = op_a * $signed({1'b0, op_b});
	end

	// Base speed in fixed point
	assign base_sel = (count_q >= crowd_count_q) ? speed_crowded_q : speed_normal_q;
	assign base_fx  = $signed(SW'({base_sel, {F{1'b0}}}));

	assign left_drv  = drive_fn(lrnd_q, dead_zone_q);
	assign right_drv = drive_fn(rrnd_q, dead_zone_q);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_threshold_q <= lfpid_pkg::RST_ADC_THRESHOLD;
			gain_p_q        <= lfpid_pkg::RST_GAIN_P;
			gain_i_q        <= lfpid_pkg::RST_GAIN_I;
			gain_d_q        <= lfpid_pkg::RST_GAIN_D;
			dead_zone_q     <= lfpid_pkg::RST_DEAD_ZONE;
			speed_normal_q  <= lfpid_pkg::RST_SPEED_NORMAL;
			speed_crowded_q <= lfpid_pkg::RST_SPEED_CROWDED;
			crowd_count_q   <= lfpid_pkg::RST_CROWD_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lfpid_pkg::REG_ADC_THRESHOLD: adc_threshold_q <= cfg_data;
				lfpid_pkg::REG_GAIN_P:        gain_p_q        <= cfg_data;
				lfpid_pkg::REG_GAIN_I:        gain_i_q        <= cfg_data;
				lfpid_pkg::REG_GAIN_D:        gain_d_q        <= cfg_data;
				lfpid_pkg::REG_DEAD_ZONE:     dead_zone_q     <= cfg_data[6:0];
				lfpid_pkg::REG_SPEED_NORMAL:  speed_normal_q  <= cfg_data;
				lfpid_pkg::REG_SPEED_CROWDED: speed_crowded_q <= cfg_data;
				lfpid_pkg::REG_CROWD_COUNT:   crowd_count_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Sequencer, controller state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lfpid_pkg::S_IDLE;
			out_valid_q  <= 1'b0;
			last_error_q <= '0;
			integ_q      <= '0;
		end else begin
			// Drop the taken result unless a new one is loaded this cycle
			if (out_valid_q && !out_stall && (state_q != lfpid_pkg::S_DRIVE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				lfpid_pkg::S_IDLE: begin
					if (in_valid) begin
						state_q <= (hit_cnt == 4'd0) ? lfpid_pkg::S_MUL_I : lfpid_pkg::S_DIV;
					end
				end
				lfpid_pkg::S_DIV: begin
					if (step_q == CW'(DW - 1)) begin
						state_q <= lfpid_pkg::S_SIGN;
					end
				end
				lfpid_pkg::S_SIGN: state_q <= lfpid_pkg::S_MUL_I;
				lfpid_pkg::S_MUL_I: begin
					integ_q <= prod[IW+7:8];
					state_q <= lfpid_pkg::S_MUL_P;
				end
				lfpid_pkg::S_MUL_P: state_q <= lfpid_pkg::S_MUL_D;
				lfpid_pkg::S_MUL_D: begin
					last_error_q <= err_q;
					state_q      <= lfpid_pkg::S_SPEED;
				end
				lfpid_pkg::S_SPEED: state_q <= lfpid_pkg::S_ROUND;
				lfpid_pkg::S_ROUND: state_q <= lfpid_pkg::S_DRIVE;
				lfpid_pkg::S_DRIVE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= lfpid_pkg::S_IDLE;
					end
				end
				default: state_q <= lfpid_pkg::S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			lfpid_pkg::S_IDLE: begin
				if (in_valid) begin
					count_q <= hit_cnt;
					neg_q   <= hit_sum[7];
					quo_q   <= dividend;
					rem_q   <= '0;
					div_q   <= {hit_cnt, 1'b0};
					step_q  <= '0;
					err_q   <= last_error_q;
				end
			end
			lfpid_pkg::S_DIV: begin
				rem_q  <= trial_ge ? 5'(trial - {1'b0, div_q}) : trial[4:0];
				quo_q  <= {quo_q[DW-2:0], trial_ge};
				step_q <= step_q + CW'(1);
			end
			lfpid_pkg::S_SIGN: begin
				err_q <= neg_q ? -$signed(EW'(quo_q)) : $signed(EW'(quo_q));
			end
			lfpid_pkg::S_MUL_P: begin
				acc_q <= $signed(prod[TW-1:0]) + TW'(integ_q);
			end
			lfpid_pkg::S_MUL_D: begin
				acc_q <= acc_q + $signed(prod[TW-1:0]);
			end
			lfpid_pkg::S_SPEED: begin
				lspd_q <= base_fx + SW'(acc_q);
				rspd_q <= base_fx - SW'(acc_q);
			end
			lfpid_pkg::S_ROUND: begin
				lrnd_q <= round_fn(lspd_q);
				rrnd_q <= round_fn(rspd_q);
			end
			lfpid_pkg::S_DRIVE: begin
				if (out_free) begin
					left_fwd_q  <= left_drv[8];
					left_pwm_q  <= left_drv[7:0];
					right_fwd_q <= right_drv[8];
					right_pwm_q <= right_drv[7:0];
					hit_count_q <= count_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign left_forward  = left_fwd_q;
	assign left_pwm      = left_pwm_q;
	assign right_forward = right_fwd_q;
	assign right_pwm     = right_pwm_q;
	assign hit_count     = hit_count_q;

	// Checks
	`ASSERT_NEXT(a_accept_starts, clk, arst_n, in_valid && !in_stall, (state_q == lfpid_pkg::S_DIV) || (state_q == lfpid_pkg::S_MUL_I))
	`ASSERT_IMPLY(a_div_starts_clean, clk, arst_n, (state_q == lfpid_pkg::S_DIV) && $past(state_q == lfpid_pkg::S_IDLE), step_q == '0)
	`ASSERT_IMPLY(a_result_from_drive, clk, arst_n, $rose(out_valid_q), $past(state_q == lfpid_pkg::S_DRIVE))
	`ASSERT_IMPLY(a_stop_not_forward, clk, arst_n, out_valid_q && ((left_pwm_q == 8'd0) || (right_pwm_q == 8'd0)), !((left_pwm_q == 8'd0) && left_fwd_q) && !((right_pwm_q == 8'd0) && right_fwd_q))

endmodule
